@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the page table walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PTW_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("page table walker assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PTW_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("page table walker assertion failed");

`endif

@@ hw/rtl/ptw_pkg.sv @@
// Types, constants and helpers shared by the page table walker files.
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } ptw_state_t;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int OFS_W             = 12;
    localparam int FRAME_W           = 40;
    localparam int VA_W              = 48;
    localparam int PA_W              = 52;
    localparam int WORD_W            = 64;
    localparam int WIDX_W            = 12;
    localparam int LVL_W             = 2;

    localparam int LVL0_SHIFT = 39;
    localparam int LVL1_SHIFT = 30;
    localparam int LVL2_SHIFT = 21;
    localparam int LVL3_SHIFT = 12;

    localparam logic [LVL_W-1:0] LVL_TOP  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_DIR  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_MID  = 2'd2;
    localparam logic [LVL_W-1:0] LVL_LAST = 2'd3;

    localparam int PRESENT_BIT     = 0;
    localparam int ENTRY_FRAME_LSB = 12;

    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    localparam int S_TDATA_W = 128;
    localparam int WIDX_LSB  = 0;
    localparam int WDATA_LSB = 12;
    localparam int VA_LSB    = 76;

    localparam int M_TDATA_W  = 56;
    localparam int PA_LSB     = 0;
    localparam int MAPPED_BIT = 52;

    localparam int   CFG_ADDR_W     = 4;
    localparam int   CFG_DATA_W     = 64;
    localparam int   CFG_SEL_BIT    = 3;
    localparam logic REG_ROOT_FRAME = 1'b0;

    function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                  input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LVL_TOP: idx = va[LVL0_SHIFT +: IDX_W];
            LVL_DIR: idx = va[LVL1_SHIFT +: IDX_W];
            LVL_MID: idx = va[LVL2_SHIFT +: IDX_W];
            default: idx = va[LVL3_SHIFT +: IDX_W];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/four_level_page_table_walker_top.sv @@
// Four-level page table walker with its own table store and root frame register.
//
// Usage:
//   The s_ channel takes one transaction per item. s_tuser selects the kind:
//   a write loads one 64-bit table word at word_index, a translate walks the
//   four table levels for virtual_address, starting at the root_frame register
//   (APB register 0, byte address 0). The m_ channel returns one transaction
//   per item: physical_address and mapped, all zero for writes and faults.
//   A translate issues its first level read with acceptance, then reads one
//   level per cycle (four dependent single-port reads), forms the result in
//   the sequencer registers and loads it into the output register once that
//   is free; on a fault it finishes sooner. A write answers through the
//   same output register. The walk sequencer holds one item at a time:
//   s_tready is high only while it is idle, so a new item is not taken
//   until the sequencer has handed the last result to the output register.
//   When the receiver stalls, the result holds in the output register; the
//   next item is still accepted and walked, and its result waits in the
//   sequencer until the output register frees.
//   Reset clears the sequencer, the output valid and root_frame. The table
//   store is not cleared: every word must be written before it is walked.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker_top
    import ptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // s_tdata: word_index[11:0], word_data[75:12], virtual_address[123:76], zero pad
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: operation[0]
    input  wire logic                  s_tuser,
    // m_tdata: physical_address[51:0], mapped[52], zero pad
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int FRAME_SEL_W = $clog2(TABLE_FRAMES);
    localparam int ADDR_W      = FRAME_SEL_W + IDX_W;
    localparam int STORE_WORDS = TABLE_FRAMES * ENTRIES_PER_TABLE;

    localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(TABLE_FRAMES);
    localparam logic [31:0]        STORE_LIMIT = 32'(STORE_WORDS);

    ptw_state_t state_reg, state_next;

    logic [FRAME_W-1:0]  root_frame_reg;
    logic [LVL_W-1:0]    level_reg, level_next, level_inc;
    logic [VA_W-1:0]     va_reg, va_next;
    logic [PA_W-1:0]     pa_reg, pa_next;
    logic                mapped_reg, mapped_next;
    logic [WORD_W-1:0]   rd_data_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [WORD_W-1:0]   store_mem [STORE_WORDS];
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [ADDR_W-1:0]   rd_addr;

    logic [WIDX_W-1:0]   in_word_index;
    logic [WORD_W-1:0]   in_word_data;
    logic [VA_W-1:0]     in_va;
    logic [FRAME_W-1:0]  next_frame;
    logic                entry_ok;
    logic                frame_ok;
    logic                root_ok;
    logic                out_free;
    logic                cfg_wr;

    assign in_word_index = s_tdata[WIDX_LSB +: WIDX_W];
    assign in_word_data  = s_tdata[WDATA_LSB +: WORD_W];
    assign in_va         = s_tdata[VA_LSB +: VA_W];

    assign next_frame = rd_data_reg[ENTRY_FRAME_LSB +: FRAME_W];
    assign entry_ok   = rd_data_reg[PRESENT_BIT];
    assign frame_ok   = next_frame < FRAME_LIMIT;
    assign root_ok    = root_frame_reg < FRAME_LIMIT;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign level_inc  = level_reg + 2'd1;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[CFG_SEL_BIT] == REG_ROOT_FRAME) ?
                    CFG_DATA_W'(root_frame_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_frame_reg <= '0;
        end else if (cfg_wr && (paddr[CFG_SEL_BIT] == REG_ROOT_FRAME)) begin
            root_frame_reg <= pwdata[FRAME_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if ((s_tuser == OP_TRANSLATE) && root_ok) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_WALK: begin
                if (!entry_ok || (level_reg == LVL_LAST) || !frame_ok) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and walk datapath
    always_comb begin
        s_tready    = 1'b0;
        level_next  = level_reg;
        va_next     = va_reg;
        pa_next     = pa_reg;
        mapped_next = mapped_reg;
        wr_en       = 1'b0;
        wr_addr     = ADDR_W'(in_word_index);
        wr_data     = in_word_data;
        rd_addr     = {next_frame[FRAME_SEL_W-1:0], va_index(va_reg, level_inc)};
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                rd_addr     = {root_frame_reg[FRAME_SEL_W-1:0], va_index(in_va, LVL_TOP)};
                if (s_tvalid) begin
                    va_next     = in_va;
                    level_next  = LVL_TOP;
                    pa_next     = '0;
                    mapped_next = 1'b0;
                    wr_en       = (s_tuser == OP_WRITE) &&
                                  (32'(in_word_index) < STORE_LIMIT);
                end
            end
            ST_WALK: begin
                if (entry_ok) begin
                    level_next = level_inc;
                    if (level_reg == LVL_LAST) begin
                        pa_next     = {next_frame, va_reg[OFS_W-1:0]};
                        mapped_next = 1'b1;
                    end
                end
            end
            ST_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            level_reg <= LVL_TOP;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        va_reg     <= va_next;
        pa_reg     <= pa_next;
        mapped_reg <= mapped_next;
    end

    // table store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_FIN) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FIN) && out_free) begin
            m_tdata_reg <= {{(M_TDATA_W - PA_W - 1){1'b0}}, mapped_reg, pa_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ptw_checker.sv @@
// Port-level assertion checker for the page table walker, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ptw_checker
    import ptw_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 pready
);

    `PTW_ASSERT_IMPLY(a_pready_high, aclk, aresetn, 1'b1, pready)

    `PTW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    `PTW_ASSERT_IMPLY(a_fault_zero, aclk, aresetn, m_tvalid && !m_tdata[MAPPED_BIT], m_tdata[PA_LSB +: PA_W] == '0)

    `PTW_ASSERT_IMPLY(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:MAPPED_BIT+1] == '0)

    `PTW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind four_level_page_table_walker_top ptw_checker u_ptw_checker (.*);

`default_nettype wire
